// ===== rtl/sems_pkg.sv =====
// ----------------------------------------------------------------------------
// sems_pkg
// types and constants shared by the shifted ensemble mean and deviation block
// ----------------------------------------------------------------------------
package sems_pkg;

  localparam int unsigned SlotCount   = 16;
  localparam int unsigned SlotBits    = 4;
  localparam int unsigned DefSections = 16;
  localparam int unsigned DefPoints   = 1024;
  localparam int unsigned DefSample   = 16;

  localparam logic [1:0] OpWrite  = 2'd0;
  localparam logic [1:0] OpLength = 2'd1;
  localparam logic [1:0] OpEntry  = 2'd2;
  localparam logic [1:0] OpPoint  = 2'd3;

  localparam logic [1:0] RegSections = 2'd0;
  localparam logic [1:0] RegOutLen   = 2'd1;
  localparam logic [1:0] RegWantDev  = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StOne   = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         slot;
    logic [9:0]         sample_index;
    logic signed [15:0] sample_value;
    logic [10:0]        trace_length;
    logic [3:0]         entry;
    logic [9:0]         shift;
    logic [9:0]         point_index;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] mean_q8;
    logic [23:0]        deviation_q8;
    logic [1:0]         status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clr;      // clear accumulators, latch item
    logic chk;      // range check of current entry
    logic rd;       // issue trace read for current entry
    logic acc_sum;  // add returned sample
    logic mean;     // start mean divide
    logic acc_sq;   // add squared deviation
    logic var_div;  // start variance divide
    logic root;     // start root
    logic next;     // advance entry counter
    logic rst_cnt;  // restart entry counter
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;     // entry counter at n-1
    logic div_done;
    logic root_done;
    logic bad;      // range error found
    logic n_one;
    logic want_dev;
  } stat_t;

endpackage

// ===== rtl/shifted_ensemble_mean_and_sd.sv =====
// ----------------------------------------------------------------------------
// shifted_ensemble_mean_and_sd
// shifted ensemble average of stored traces with optional sample deviation
// ----------------------------------------------------------------------------
//  channel   signals                       direction  transfer when
//  command   start_i, busy_o, item_i       in         start_i && !busy_o
//  result    result_valid_o, result_o      out        result_valid_o
//  config    cfg_we_i, cfg_idx_i, cfg_data_i in       cfg_we_i
//
// load opcodes do not raise busy. a point runs a range check over the n
// sections and a sum pass, then the mean divide, then with deviation a second
// pass, the variance divide and the root, then the done state; busy drops in
// the cycle that carries the strobe.
// reset clears tables and config; trace memory is not cleared.
// the result strobe lasts one cycle; the receiver cannot stall.
module shifted_ensemble_mean_and_sd
  import sems_pkg::*;
#(
  parameter int unsigned MaxSections = DefSections,
  parameter int unsigned MaxPoints   = DefPoints,
  parameter int unsigned SampleBits  = DefSample
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_item_t  item_i,
  output logic      result_valid_o,
  output out_item_t result_o,
  input  logic      cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);
  logic [4:0]  sections_q;
  logic [10:0] out_len_q;
  logic        want_dev_q;
  logic        accept, busy, done;
  cmd_t        cmd;
  stat_t       stat;
  out_item_t   res;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sections_q <= 5'd1;
      out_len_q  <= 11'd1024;
      want_dev_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSections: sections_q <= cfg_data_i[4:0];
        RegOutLen:   out_len_q  <= cfg_data_i;
        RegWantDev:  want_dev_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign accept = start_i && !busy;
  assign busy_o = busy;

  sems_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .go_i(accept && item_i.opcode == OpPoint),
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy), .done_o(done)
  );

  sems_dp #(
    .MaxSections(MaxSections), .MaxPoints(MaxPoints), .SampleBits(SampleBits)
  ) u_dp (
    .clk_i, .rst_ni,
    .accept_i(accept), .item_i,
    .sections_i(sections_q), .out_len_i(out_len_q), .want_dev_i(want_dev_q),
    .cmd_i(cmd), .stat_o(stat), .result_o(res)
  );

  // registered result, one cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) result_o <= res;
  end

  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("strobe held");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.status == StOk || result_o.status == StRange
                        || result_o.status == StOne)) else $error("bad status");
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == StRange) |-> result_o.mean_q8 == '0)
    else $error("range result not zero");
endmodule

// ===== rtl/sems_ram.sv =====
// ----------------------------------------------------------------------------
// sems_ram
// single port write, single port registered read memory
// ----------------------------------------------------------------------------
module sems_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/sems_div.sv =====
// ----------------------------------------------------------------------------
// sems_div
// restoring divider, one quotient bit a cycle, 64 by 7-bit divisor
// ----------------------------------------------------------------------------
module sems_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [6:0]  den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q, quo_d;
  logic [6:0]  rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [6:0]  den_q;
  logic [7:0]  trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[63]};
    done_o = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 7'(trial - {1'b0, den_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial[6:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = 7'(cnt_q + 7'd1);
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quo_o = quo_d;
endmodule

// ===== rtl/sems_sqrt.sv =====
// ----------------------------------------------------------------------------
// sems_sqrt
// digit-by-digit integer square root, one result bit a cycle
// ----------------------------------------------------------------------------
module sems_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] v_q, v_d;
  logic [63:0] r_q, r_d;
  logic [63:0] bit_q, bit_d;
  logic        busy_q, busy_d;
  logic [63:0] trial;

  always_comb begin
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_o = 1'b0;
    trial  = r_q + bit_q;
    if (start_i) begin
      v_d    = val_i;
      r_d    = '0;
      bit_d  = 64'd1 << 62;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d = v_q - trial;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign root_o = r_d[31:0];
endmodule

// ===== rtl/sems_ctrl.sv =====
// ----------------------------------------------------------------------------
// sems_ctrl
// sequencer for the range check, sum pass, deviation pass, divide and root
// ----------------------------------------------------------------------------
module sems_ctrl
  import sems_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  go_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o,
  output logic  done_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD1, S_SUM, S_MDIV, S_RD2, S_SQ, S_VDIV, S_ROOT, S_DONE
  } state_e;

  state_e state_q;
  logic   pend_q;

  always_comb begin
    cmd_o   = '0;
    busy_o  = (state_q != S_IDLE);
    done_o  = (state_q == S_DONE);
    case (state_q)
      S_IDLE:  cmd_o.clr = go_i;
      S_CHECK: begin
        cmd_o.chk = 1'b1;
        cmd_o.next = !stat_i.last;
        cmd_o.rst_cnt = stat_i.last;
      end
      S_RD1: begin
        cmd_o.rd = !pend_q;
        cmd_o.acc_sum = pend_q;
        cmd_o.next = pend_q && !stat_i.last;
        cmd_o.rst_cnt = pend_q && stat_i.last;
      end
      S_MDIV:  cmd_o.mean = !pend_q;
      S_RD2: begin
        cmd_o.rd = !pend_q;
        cmd_o.acc_sq = pend_q;
        cmd_o.next = pend_q && !stat_i.last;
      end
      S_VDIV:  cmd_o.var_div = !pend_q;
      S_ROOT:  cmd_o.root = !pend_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE:  if (go_i) state_q <= S_CHECK;
        S_CHECK: if (stat_i.last) begin
          state_q <= S_RD1;
          pend_q  <= 1'b0;
        end
        S_RD1: begin
          pend_q <= !pend_q;
          if (pend_q && stat_i.last) begin
            state_q <= stat_i.bad ? S_DONE : S_MDIV;
          end
        end
        S_MDIV: begin
          pend_q <= 1'b1;
          if (stat_i.div_done) begin
            pend_q <= 1'b0;
            state_q <= (!stat_i.want_dev || stat_i.n_one) ? S_DONE : S_RD2;
          end
        end
        S_RD2: begin
          pend_q <= !pend_q;
          if (pend_q && stat_i.last) state_q <= S_VDIV;
        end
        S_VDIV: begin
          pend_q <= 1'b1;
          if (stat_i.div_done) begin
            pend_q  <= 1'b0;
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          pend_q <= 1'b1;
          if (stat_i.root_done) begin
            pend_q  <= 1'b0;
            state_q <= S_DONE;
          end
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr |-> !busy_o) else $error("start while busy");
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mean && cmd_o.root)) else $error("units overlap");
endmodule

// ===== rtl/sems_dp.sv =====
// ----------------------------------------------------------------------------
// sems_dp
// tables, trace memory, accumulators and arithmetic units
// ----------------------------------------------------------------------------
module sems_dp
  import sems_pkg::*;
#(
  parameter int unsigned MaxSections = DefSections,
  parameter int unsigned MaxPoints   = DefPoints,
  parameter int unsigned SampleBits  = DefSample
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_item_t  item_i,
  input  logic [4:0]  sections_i,
  input  logic [10:0] out_len_i,
  input  logic        want_dev_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output out_item_t result_o
);
  localparam int unsigned EntBits = $clog2(MaxSections);
  localparam int unsigned PtBits  = $clog2(MaxPoints);
  localparam int unsigned AdrBits = SlotBits + PtBits;
  localparam int unsigned LenBits = PtBits + 1;

  logic [LenBits-1:0]  len_q  [SlotCount];
  logic [SlotBits-1:0] eslot_q [MaxSections];
  logic [9:0]          eshift_q [MaxSections];
  logic [EntBits-1:0]  cnt_q;
  logic [EntBits:0]    n_q;
  logic [9:0]          point_q;
  logic                bad_q, want_q;
  logic signed [SampleBits+EntBits:0] sum_q;
  logic signed [23:0]  mean_q;
  logic [63:0]         acc_q;
  logic [23:0]         dev_q;
  logic [SampleBits-1:0] rdata;
  logic signed [SampleBits-1:0] x;
  logic [AdrBits-1:0]  waddr, raddr;
  logic [PtBits-1:0]   pos;
  logic [11:0]         lim;
  logic signed [SampleBits+8:0] d;
  logic [SampleBits+8:0] ad;
  logic [63:0]         sq, acc_n;
  logic [64:0]         acc_s;
  logic [63:0]         mag, dnum, quo;
  logic [6:0]          dden;
  logic                ddone, rdone;
  logic [31:0]         root;
  logic [EntBits:0]    n_d;
  logic [SampleBits+EntBits:0] sum_abs;

  always_comb begin
    n_d = (EntBits + 1)'(sections_i);
    if (sections_i == 5'd0) n_d = (EntBits + 1)'(1);
    if (32'(sections_i) > MaxSections) n_d = (EntBits + 1)'(MaxSections);
  end

  assign pos   = PtBits'(32'(point_q) + 32'(eshift_q[cnt_q]));
  assign raddr = {eslot_q[cnt_q], pos};
  assign waddr = {item_i.slot, PtBits'(item_i.sample_index)};
  assign lim   = 12'(out_len_i) + 12'(eshift_q[cnt_q]);

  sems_ram #(.Width(SampleBits), .Depth(SlotCount * MaxPoints)) u_ram (
    .clk_i,
    .we_i   (accept_i && item_i.opcode == OpWrite
             && 32'(item_i.sample_index) < MaxPoints),
    .waddr_i(waddr),
    .wdata_i(SampleBits'(item_i.sample_value)),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );
  assign x = $signed(rdata);

  // deviation term: x*256 - mean, squared with saturation
  assign d  = ((SampleBits+9)'(x) <<< 8) - (SampleBits+9)'(mean_q);
  assign ad = d[SampleBits+8] ? (SampleBits+9)'(-d) : (SampleBits+9)'(d);
  always_comb begin
    if (64'(ad) > 64'hFFFF_FFFF) sq = '1;
    else sq = 64'(ad) * 64'(ad);
    acc_s = 65'(acc_q) + 65'(sq);
    acc_n = acc_s[64] ? '1 : acc_s[63:0];
  end

  assign sum_abs = sum_q[SampleBits+EntBits] ? (SampleBits+EntBits+1)'(-sum_q)
                                             : (SampleBits+EntBits+1)'(sum_q);
  assign mag  = 64'(sum_abs) << 8;
  assign dnum = cmd_i.mean ? mag : acc_q;
  assign dden = cmd_i.mean ? 7'(n_q) : 7'(n_q - 1'b1);

  sems_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.mean || cmd_i.var_div),
    .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(quo)
  );

  sems_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i(cmd_i.root), .val_i(acc_q),
    .done_o(rdone), .root_o(root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) len_q[i] <= '0;
      for (int i = 0; i < MaxSections; i++) begin
        eslot_q[i]  <= '0;
        eshift_q[i] <= '0;
      end
      cnt_q <= '0;
    end else begin
      if (accept_i && item_i.opcode == OpLength) begin
        len_q[item_i.slot] <= (32'(item_i.trace_length) > MaxPoints)
                              ? LenBits'(MaxPoints) : LenBits'(item_i.trace_length);
      end
      if (accept_i && item_i.opcode == OpEntry && 32'(item_i.entry) < MaxSections) begin
        eslot_q[EntBits'(item_i.entry)]  <= item_i.slot;
        eshift_q[EntBits'(item_i.entry)] <= item_i.shift;
      end
      if (cmd_i.clr || cmd_i.rst_cnt) cnt_q <= '0;
      else if (cmd_i.next) cnt_q <= EntBits'(cnt_q + 1'b1);
    end
  end

  logic mdiv_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      point_q <= item_i.point_index;
      n_q     <= n_d;
      want_q  <= want_dev_i;
      bad_q   <= (11'(item_i.point_index) >= out_len_i);
      sum_q   <= '0;
      acc_q   <= '0;
      mean_q  <= '0;
      dev_q   <= '0;
      mdiv_q  <= 1'b0;
    end
    if (cmd_i.chk && lim > 12'(len_q[eslot_q[cnt_q]])) bad_q <= 1'b1;
    if (cmd_i.acc_sum) sum_q <= sum_q + (SampleBits+EntBits+1)'(x);
    if (cmd_i.acc_sq) acc_q <= acc_n;
    if (cmd_i.mean) mdiv_q <= 1'b1;
    if (cmd_i.var_div) mdiv_q <= 1'b0;
    if (ddone && mdiv_q) begin
      if (sum_q[SampleBits+EntBits])
        mean_q <= (quo > 64'd8388608) ? 24'sh800000 : 24'(-quo);
      else
        mean_q <= (quo > 64'd8388607) ? 24'sh7FFFFF : 24'(quo);
    end
    if (ddone && !mdiv_q) acc_q <= quo;
    if (rdone) dev_q <= (root > 32'hFF_FFFF) ? 24'hFF_FFFF : root[23:0];
  end

  assign stat_o.last      = (32'(cnt_q) == 32'(n_q) - 1);
  assign stat_o.div_done  = ddone;
  assign stat_o.root_done = rdone;
  assign stat_o.bad       = bad_q;
  assign stat_o.n_one     = (n_q == (EntBits + 1)'(1));
  assign stat_o.want_dev  = want_q;

  always_comb begin
    result_o = '0;
    if (bad_q) begin
      result_o.status = StRange;
    end else begin
      result_o.mean_q8 = mean_q;
      if (want_q && n_q == (EntBits + 1)'(1)) result_o.status = StOne;
      else if (want_q) result_o.deviation_q8 = dev_q;
    end
  end
endmodule
